// File: rtl/rgd_pkg.sv
`default_nettype none

package rgd_pkg;

	// Gesture direction codes as they appear on the result fields.
	typedef enum logic [1:0] {
		DIR_NONE  = 2'd0,
		DIR_LEFT  = 2'd1,
		DIR_RIGHT = 2'd2
	} dir_t;

	// Item sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_DRAIN,
		ST_DECIDE
	} state_t;

	// Configuration register indexes.
	localparam int CfgIdxW = 2;
	localparam logic [CfgIdxW-1:0] CFG_ACTIVITY_THRESHOLD    = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_LIKELIHOOD_WEIGHT_MIN = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_MIN_GESTURE_MS        = 2'd2;
	localparam int CfgDataW = 16;

	// Register widths and reset values.
	localparam int ThrW = 16;
	localparam int LwW  = 14;
	localparam int MinW = 16;
	localparam logic [ThrW-1:0] THR_RESET = 16'd180;
	localparam logic [LwW-1:0]  LW_RESET  = 14'd325;
	localparam logic [MinW-1:0] MIN_RESET = 16'd1000;

	// Item field widths.
	localparam int SampleW = 16;
	localparam int TimeW   = 32;
	localparam int InDataW = 48;
	localparam int OutDataW = 8;

endpackage

`default_nettype wire

// File: rtl/roll_gesture_detector.sv
`default_nettype none

// Channel   Direction  Payload bits (low to high)                               Role
// s_*       in         tdata: roll_sample[15:0], now_ms[47:16]; tuser: kind      samples, clears
// m_*       out        tdata: active_direction[1:0], changed[2],                  one result per item
//                             recognized_direction[4:3], zero[7:5]
// cfg_*     in         cfg_index selects the register, cfg_data carries its value  setup writes
//
// A sample item with a full window passes through these steps before the next item is accepted:
// accept, write the window memory, read the whole window through its single read port, drain
// the read data and update the gesture state. Until the window is full a sample skips the read
// and the drain; a clear goes straight from acceptance to the update.
// The window needs no clearing pass after reset; only its fill count is cleared.
// A stalled result waits in the output register while the next item is accepted and worked
// on; only the final state update waits for the output register to be free.
module roll_gesture_detector #(
	parameter int WINDOW = 12
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Input stream.
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [rgd_pkg::InDataW-1:0]       s_tdata,  // roll_sample, now_ms
	input  wire logic                              s_tuser,  // kind
	// Result stream.
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [rgd_pkg::OutDataW-1:0]           m_tdata,  // active, changed, recognized
	// Configuration writes.
	input  wire logic                              cfg_wr_en,
	input  wire logic [rgd_pkg::CfgIdxW-1:0]       cfg_index,
	input  wire logic [rgd_pkg::CfgDataW-1:0]      cfg_data
);

	// Index of a window entry, count of filled entries, and a width that holds the
	// largest weighted sum (sum of k^2 for k up to WINDOW) as well as the threshold.
	localparam int IW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW     = $clog2(WINDOW + 1);
	localparam int WSUM   = WINDOW * (WINDOW + 1) * (2 * WINDOW + 1) / 6;
	localparam int WBITS  = $clog2(WSUM + 1);
	localparam int WW     = (WBITS > rgd_pkg::LwW) ? WBITS : rgd_pkg::LwW;
	localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(WINDOW);
	localparam logic [IW:0]   WRAP_ADD = (IW + 1)'(WINDOW);

	// Configuration registers.
	logic [rgd_pkg::ThrW-1:0] thr_q;
	logic [rgd_pkg::LwW-1:0]  lw_q;
	logic [rgd_pkg::MinW-1:0] min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= rgd_pkg::THR_RESET;
			lw_q  <= rgd_pkg::LW_RESET;
			min_q <= rgd_pkg::MIN_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				rgd_pkg::CFG_ACTIVITY_THRESHOLD:    thr_q <= cfg_data;
				rgd_pkg::CFG_LIKELIHOOD_WEIGHT_MIN: lw_q  <= cfg_data[rgd_pkg::LwW-1:0];
				rgd_pkg::CFG_MIN_GESTURE_MS:        min_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer.
	rgd_pkg::state_t state_q, state_d;

	logic                         kind_q;
	logic [rgd_pkg::SampleW-1:0]  sample_q;
	logic [rgd_pkg::TimeW-1:0]    now_q;

	logic [IW-1:0] head_q;     // physical entry holding the oldest sample
	logic [CW-1:0] fill_q;
	logic [IW-1:0] rd_addr_q;
	logic [IW-1:0] rd_cnt_q;

	logic out_free;
	logic accept;

	assign out_free = !m_tvalid || m_tready;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rgd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			rgd_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = s_tuser ? rgd_pkg::ST_DECIDE : rgd_pkg::ST_WRITE;
				end
			end
			rgd_pkg::ST_WRITE: begin
				// The window is full after this write if it was full or one short.
				if (fill_q == FULL_CNT || fill_q == CW'(WINDOW - 1)) begin
					state_d = rgd_pkg::ST_READ;
				end else begin
					state_d = rgd_pkg::ST_DECIDE;
				end
			end
			rgd_pkg::ST_READ: begin
				if (rd_cnt_q == LAST_IDX) begin
					state_d = rgd_pkg::ST_DRAIN;
				end
			end
			rgd_pkg::ST_DRAIN: begin
				state_d = rgd_pkg::ST_DECIDE;
			end
			rgd_pkg::ST_DECIDE: begin
				if (out_free) begin
					state_d = rgd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rgd_pkg::ST_IDLE;
			end
		endcase
	end

	// Accepted item.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= s_tuser;
			sample_q <= s_tdata[rgd_pkg::SampleW-1:0];
			now_q    <= s_tdata[rgd_pkg::SampleW +: rgd_pkg::TimeW];
		end
	end

	// Window memory: a circular buffer, oldest entry at head_q.
	logic [rgd_pkg::SampleW-1:0] win_mem [WINDOW];
	logic [rgd_pkg::SampleW-1:0] rd_data_s1;
	logic [IW-1:0]               wr_addr;
	logic [IW:0]                 wr_sum;
	logic [IW-1:0]               head_inc;
	logic                        win_full;

	assign win_full = (fill_q == FULL_CNT);
	assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign wr_sum   = {1'b0, head_q} + {1'b0, fill_q[IW-1:0]};

	always_comb begin
		if (win_full) begin
			wr_addr = head_q;
		end else if (wr_sum >= WRAP_ADD) begin
			wr_addr = IW'(wr_sum - WRAP_ADD);
		end else begin
			wr_addr = wr_sum[IW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rgd_pkg::ST_WRITE) begin
			win_mem[wr_addr] <= sample_q;
		end
		rd_data_s1 <= win_mem[rd_addr_q];
	end

	// Fill count, head and read walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			head_q    <= '0;
			rd_addr_q <= '0;
			rd_cnt_q  <= '0;
		end else begin
			unique case (state_q)
				rgd_pkg::ST_WRITE: begin
					rd_cnt_q <= '0;
					if (win_full) begin
						head_q    <= head_inc;
						rd_addr_q <= head_inc;
					end else begin
						fill_q    <= fill_q + 1'b1;
						rd_addr_q <= head_q;
					end
				end
				rgd_pkg::ST_READ: begin
					rd_cnt_q  <= rd_cnt_q + 1'b1;
					rd_addr_q <= (rd_addr_q == LAST_IDX) ? '0 : rd_addr_q + 1'b1;
				end
				rgd_pkg::ST_DECIDE: begin
					if (out_free && kind_q) begin
						fill_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Read data arrives in the cycle after its address, tagged with its window position.
	logic          rv_s1;
	logic [IW-1:0] ridx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
		end else begin
			rv_s1 <= (state_q == rgd_pkg::ST_READ);
		end
	end

	always_ff @(posedge clk) begin
		ridx_s1 <= rd_cnt_q;
	end

	// Delta scoring. Each delta between neighbors whose magnitude exceeds the activity
	// threshold adds (position+1)^2, where position counts from the oldest entry.
	logic [rgd_pkg::SampleW-1:0] prev_q;
	logic [rgd_pkg::SampleW-1:0] oldest_q;
	logic [WW-1:0]               weight_q;
	logic                        left_q;
	logic signed [rgd_pkg::SampleW:0] delta;
	logic signed [rgd_pkg::SampleW:0] span;
	logic [rgd_pkg::SampleW:0]        delta_mag;
	logic [IW:0]                      pos1;
	logic [2*IW+1:0]                  pos_sq;

	assign delta = $signed({rd_data_s1[rgd_pkg::SampleW-1], rd_data_s1})
	             - $signed({prev_q[rgd_pkg::SampleW-1], prev_q});
	assign span  = $signed({rd_data_s1[rgd_pkg::SampleW-1], rd_data_s1})
	             - $signed({oldest_q[rgd_pkg::SampleW-1], oldest_q});
	assign delta_mag = delta[rgd_pkg::SampleW] ? (rgd_pkg::SampleW + 1)'(-delta)
	                                           : (rgd_pkg::SampleW + 1)'(delta);
	assign pos1   = {1'b0, ridx_s1} + 1'b1;
	assign pos_sq = pos1 * pos1;

	always_ff @(posedge clk) begin
		if (state_q == rgd_pkg::ST_WRITE) begin
			weight_q <= '0;
		end else if (rv_s1) begin
			prev_q <= rd_data_s1;
			if (ridx_s1 == '0) begin
				oldest_q <= rd_data_s1;
			end else if (delta_mag > {1'b0, thr_q}) begin
				weight_q <= weight_q + WW'(pos_sq);
			end
			if (ridx_s1 == LAST_IDX) begin
				left_q <= !span[rgd_pkg::SampleW];
			end
		end
	end

	// Gesture state.
	rgd_pkg::dir_t rec_type_q, act_type_q;
	logic [rgd_pkg::TimeW-1:0] rec_begin_q, act_begin_q;

	rgd_pkg::dir_t             rec_type_d, act_type_d;
	logic [rgd_pkg::TimeW-1:0] rec_begin_d, act_begin_d;
	logic                      changed_d;
	logic                      hit;
	logic                      rec_hold;
	logic [rgd_pkg::TimeW-1:0] rec_age, act_age;

	assign rec_age  = now_q - rec_begin_q;
	assign act_age  = now_q - act_begin_q;
	assign hit      = win_full && (weight_q >= WW'(lw_q));
	assign rec_hold = (rec_type_q != rgd_pkg::DIR_NONE)
	               && (rec_age < rgd_pkg::TimeW'(min_q));

	always_comb begin
		rec_type_d  = rec_type_q;
		rec_begin_d = rec_begin_q;
		act_type_d  = act_type_q;
		act_begin_d = act_begin_q;
		changed_d   = 1'b0;
		if (kind_q) begin
			// A clear empties the window and drops both gestures.
			rec_type_d  = rgd_pkg::DIR_NONE;
			rec_begin_d = now_q;
			act_type_d  = rgd_pkg::DIR_NONE;
			act_begin_d = now_q;
		end else begin
			// A recognized gesture is held for the minimum duration.
			if (!rec_hold) begin
				if (rec_type_q == rgd_pkg::DIR_NONE && hit) begin
					rec_type_d  = left_q ? rgd_pkg::DIR_LEFT : rgd_pkg::DIR_RIGHT;
					rec_begin_d = now_q;
				end else if (rec_type_q != rgd_pkg::DIR_NONE && !hit) begin
					rec_type_d = rgd_pkg::DIR_NONE;
				end
			end
			// Activation once the previous active span is old enough, or cancel
			// when the new recognition points the other way.
			if (act_type_q == rgd_pkg::DIR_NONE && rec_type_d != rgd_pkg::DIR_NONE
			    && act_age > rgd_pkg::TimeW'(min_q)) begin
				act_type_d  = rec_type_d;
				act_begin_d = rec_begin_d;
				changed_d   = 1'b1;
			end else if ((act_type_q == rgd_pkg::DIR_LEFT && rec_type_d == rgd_pkg::DIR_RIGHT)
			          || (act_type_q == rgd_pkg::DIR_RIGHT && rec_type_d == rgd_pkg::DIR_LEFT)) begin
				act_type_d  = rgd_pkg::DIR_NONE;
				act_begin_d = rec_begin_d;
				changed_d   = 1'b1;
			end
		end
	end

	logic decide_fire;
	assign decide_fire = (state_q == rgd_pkg::ST_DECIDE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_type_q  <= rgd_pkg::DIR_NONE;
			rec_begin_q <= '0;
			act_type_q  <= rgd_pkg::DIR_NONE;
			act_begin_q <= '0;
		end else if (decide_fire) begin
			rec_type_q  <= rec_type_d;
			rec_begin_q <= rec_begin_d;
			act_type_q  <= act_type_d;
			act_begin_q <= act_begin_d;
		end
	end

	// Output register.
	logic                         m_valid_q;
	logic [rgd_pkg::OutDataW-1:0] m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (decide_fire) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (decide_fire) begin
			m_data_q <= {3'b000, rec_type_d, changed_d, act_type_d};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

`default_nettype wire
